>>> design/mcfb_pkg.sv
// Shared constants, codes and types of the multi-channel bounded FIFO bus.
// Depends on nothing; the top level, the result checker and the testbench import it.
package mcfb_pkg;

   localparam int NUM_CHANNELS  = 8;
   localparam int CHANNEL_DEPTH = 16;
   localparam int MAX_BURST     = 16;
   localparam int RESULT_CAP    = 16;

   localparam int BURST_CAP   = (MAX_BURST < RESULT_CAP) ? MAX_BURST : RESULT_CAP;
   localparam int SLOT_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PTR_W       = (CHANNEL_DEPTH > 1) ? $clog2(CHANNEL_DEPTH) : 1;
   localparam int FILL_W      = $clog2(CHANNEL_DEPTH + 1);
   localparam int SUM_W       = (PTR_W > FILL_W ? PTR_W : FILL_W) + 1;
   localparam int BURST_W     = $clog2(BURST_CAP + 1);
   localparam int STORE_DEPTH = NUM_CHANNELS * CHANNEL_DEPTH;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int WORD_W      = 32;

   typedef enum logic [2:0] {
      REQ_OPEN  = 3'd0,
      REQ_CLOSE = 3'd1,
      REQ_SEND  = 3'd2,
      REQ_RECV  = 3'd3,
      REQ_BCAST = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_NO_CHANNEL   = 2'd1,
      ST_WOULD_BLOCK  = 2'd2,
      ST_NO_FREE_SLOT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OPEN_SCAN,
      S_SINGLE,
      S_RD_ISSUE,
      S_RD_WAIT,
      S_BC_SCAN,
      S_BC_PUSH,
      S_EMIT
   } state_type;

endpackage

>>> design/mcfb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module mcfb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/multi_channel_bounded_fifo_bus.sv
// Top level of the multi-channel bounded FIFO bus: slot registers, sequencer, result register.
// Depends on mcfb_pkg and mcfb_ram.
//
//   Channel   Direction   Handshake                Payload
//   req_      in          req_valid / req_stall    req_type, channel_sel, send_data,
//                                                  limit_words, burst_count
//   rsp_      out         rsp_valid / rsp_stall    status, opened_id, recv_data, last
//
// Close and send pass from the single-slot state through the emit state, which registers
// the result; the sequencer then returns to idle to take the next item. Open examines one
// slot a cycle until it finds a free one or reaches the last slot; broadcast scans the
// slots and, when one is open and no open slot is full, writes every open slot. A receive
// issues each read and registers the word from the word store's registered read port, one
// word per read, until the burst ends or the slot is empty. Reset clears all slots at once.
// A stalled result holds the sequencer until it is taken.
module multi_channel_bounded_fifo_bus
   import mcfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_channel_sel,
   input  logic [31:0] req_send_data,
   input  logic [4:0]  req_limit_words,
   input  logic [4:0]  req_burst_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_opened_id,
   output logic [31:0] rsp_recv_data,
   output logic        rsp_last
);

   state_type state_ff, state_in;

   logic [2:0]         req_ff, req_in;
   logic               range_ok_ff, range_ok_in;
   logic [WORD_W-1:0]  data_ff, data_in;
   logic [FILL_W-1:0]  lim_ff, lim_in;
   logic [BURST_W-1:0] burst_ff, burst_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               any_ff, any_in;
   logic               rd_last_ff, rd_last_in;
   status_type         res_status_ff, res_status_in;
   logic [SLOT_W-1:0]  res_id_ff, res_id_in;

   logic               open_ff  [NUM_CHANNELS];
   logic               open_in  [NUM_CHANNELS];
   logic [FILL_W-1:0]  limit_ff [NUM_CHANNELS];
   logic [FILL_W-1:0]  limit_in [NUM_CHANNELS];
   logic [PTR_W-1:0]   rptr_ff  [NUM_CHANNELS];
   logic [PTR_W-1:0]   rptr_in  [NUM_CHANNELS];
   logic [FILL_W-1:0]  fill_ff  [NUM_CHANNELS];
   logic [FILL_W-1:0]  fill_in  [NUM_CHANNELS];

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [2:0]         rsp_id_ff, rsp_id_in;
   logic [WORD_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   logic               out_free;
   logic               cur_open;
   logic [FILL_W-1:0]  cur_limit;
   logic [PTR_W-1:0]   cur_rptr;
   logic [FILL_W-1:0]  cur_fill;
   logic               cur_full;
   logic               sel_ok;
   logic               last_slot;
   logic [SUM_W-1:0]   pos_sum;
   logic [PTR_W-1:0]   wr_pos;
   logic [PTR_W-1:0]   rptr_next;
   logic [ADDR_W-1:0]  slot_base;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [WORD_W-1:0]  ram_rd_data;

   mcfb_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (data_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign cur_open  = open_ff[slot_ff];
   assign cur_limit = limit_ff[slot_ff];
   assign cur_rptr  = rptr_ff[slot_ff];
   assign cur_fill  = fill_ff[slot_ff];
   assign cur_full  = (cur_fill >= cur_limit);
   assign sel_ok    = range_ok_ff && cur_open;
   assign last_slot = (slot_ff == SLOT_W'(NUM_CHANNELS - 1));

   assign pos_sum   = SUM_W'(cur_rptr) + SUM_W'(cur_fill);
   assign wr_pos    = (pos_sum >= SUM_W'(CHANNEL_DEPTH)) ?
                      PTR_W'(pos_sum - SUM_W'(CHANNEL_DEPTH)) : PTR_W'(pos_sum);
   assign rptr_next = (cur_rptr == PTR_W'(CHANNEL_DEPTH - 1)) ? '0 : cur_rptr + 1'b1;
   assign slot_base = ADDR_W'(slot_ff) * ADDR_W'(CHANNEL_DEPTH);

   assign ram_wr_addr = slot_base + ADDR_W'(wr_pos);
   assign ram_rd_addr = slot_base + ADDR_W'(cur_rptr);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_type) inside
                  REQ_OPEN: state_in = S_OPEN_SCAN;
                  REQ_CLOSE, REQ_SEND, REQ_RECV: state_in = S_SINGLE;
                  REQ_BCAST: state_in = S_BC_SCAN;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_OPEN_SCAN: begin
            if (!cur_open || last_slot) begin
               state_in = S_EMIT;
            end
         end
         S_SINGLE: begin
            if (req_ff == REQ_RECV && sel_ok && cur_fill != '0) begin
               state_in = S_RD_ISSUE;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_RD_ISSUE: state_in = S_RD_WAIT;
         S_RD_WAIT: begin
            if (out_free) begin
               state_in = rd_last_ff ? S_IDLE : S_RD_ISSUE;
            end
         end
         S_BC_SCAN: begin
            if (cur_open && cur_full) begin
               state_in = S_EMIT;
            end else if (last_slot) begin
               state_in = (any_ff || cur_open) ? S_BC_PUSH : S_EMIT;
            end
         end
         S_BC_PUSH: begin
            if (last_slot) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_in        = req_ff;
      range_ok_in   = range_ok_ff;
      data_in       = data_ff;
      lim_in        = lim_ff;
      burst_in      = burst_ff;
      slot_in       = slot_ff;
      any_in        = any_ff;
      rd_last_in    = rd_last_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      open_in       = open_ff;
      limit_in      = limit_ff;
      rptr_in       = rptr_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in      = req_type;
               range_ok_in = (32'(req_channel_sel) < NUM_CHANNELS);
               data_in     = req_send_data;
               lim_in      = (32'(req_limit_words) > CHANNEL_DEPTH) ?
                             FILL_W'(CHANNEL_DEPTH) : FILL_W'(req_limit_words);
               if (req_burst_count == '0) begin
                  burst_in = BURST_W'(1);
               end else if (32'(req_burst_count) > BURST_CAP) begin
                  burst_in = BURST_W'(BURST_CAP);
               end else begin
                  burst_in = BURST_W'(req_burst_count);
               end
               slot_in   = (req_type == REQ_OPEN || req_type == REQ_BCAST) ?
                           '0 : SLOT_W'(req_channel_sel);
               any_in    = 1'b0;
               res_id_in = '0;
            end
         end
         S_OPEN_SCAN: begin
            if (!cur_open) begin
               open_in[slot_ff]  = 1'b1;
               limit_in[slot_ff] = lim_ff;
               rptr_in[slot_ff]  = '0;
               fill_in[slot_ff]  = '0;
               res_status_in     = ST_OK;
               res_id_in         = slot_ff;
            end else if (last_slot) begin
               res_status_in = ST_NO_FREE_SLOT;
               res_id_in     = '0;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         S_SINGLE: begin
            res_status_in = ST_OK;
            case (req_ff)
               REQ_CLOSE: begin
                  if (sel_ok) begin
                     open_in[slot_ff]  = 1'b0;
                     limit_in[slot_ff] = '0;
                     rptr_in[slot_ff]  = '0;
                     fill_in[slot_ff]  = '0;
                  end
               end
               REQ_SEND: begin
                  if (!sel_ok) begin
                     res_status_in = ST_NO_CHANNEL;
                  end else if (cur_full) begin
                     res_status_in = ST_WOULD_BLOCK;
                  end else begin
                     ram_wr_en        = 1'b1;
                     fill_in[slot_ff] = cur_fill + 1'b1;
                  end
               end
               REQ_RECV: begin
                  if (!sel_ok) begin
                     res_status_in = ST_NO_CHANNEL;
                  end else if (cur_fill == '0) begin
                     res_status_in = ST_WOULD_BLOCK;
                  end
               end
               default: res_status_in = ST_OK;
            endcase
         end
         S_RD_ISSUE: begin
            ram_rd_en        = 1'b1;
            rptr_in[slot_ff] = rptr_next;
            fill_in[slot_ff] = cur_fill - 1'b1;
            burst_in         = burst_ff - 1'b1;
            rd_last_in       = (burst_ff == BURST_W'(1)) || (cur_fill == FILL_W'(1));
         end
         S_RD_WAIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_id_in     = '0;
               rsp_data_in   = ram_rd_data;
               rsp_last_in   = rd_last_ff;
            end
         end
         S_BC_SCAN: begin
            if (cur_open) begin
               any_in = 1'b1;
            end
            if (cur_open && cur_full) begin
               res_status_in = ST_WOULD_BLOCK;
            end else if (last_slot) begin
               res_status_in = ST_NO_CHANNEL;
               slot_in       = '0;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         S_BC_PUSH: begin
            if (cur_open) begin
               ram_wr_en        = 1'b1;
               fill_in[slot_ff] = cur_fill + 1'b1;
            end
            if (last_slot) begin
               res_status_in = ST_OK;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = 3'(res_id_ff);
               rsp_data_in   = '0;
               rsp_last_in   = 1'b1;
            end
         end
         default: rsp_valid_in = rsp_valid_ff && rsp_stall;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            open_ff[i]  <= 1'b0;
            limit_ff[i] <= '0;
            rptr_ff[i]  <= '0;
            fill_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         open_ff      <= open_in;
         limit_ff     <= limit_in;
         rptr_ff      <= rptr_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      range_ok_ff   <= range_ok_in;
      data_ff       <= data_in;
      lim_ff        <= lim_in;
      burst_ff      <= burst_in;
      slot_ff       <= slot_in;
      any_ff        <= any_in;
      rd_last_ff    <= rd_last_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_opened_id = rsp_id_ff;
   assign rsp_recv_data = rsp_data_ff;
   assign rsp_last      = rsp_last_ff;

   a_fill_within_limit: assert property (@(posedge clock) disable iff (reset)
      cur_open |-> cur_fill <= cur_limit)
      else $error("An open slot holds more items than its limit.");

   a_closed_slot_empty: assert property (@(posedge clock) disable iff (reset)
      !cur_open |-> cur_fill == '0)
      else $error("A closed slot still counts stored items.");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_SINGLE || state_ff == S_BC_PUSH))
      else $error("Word store written outside a push.");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD_WAIT && out_free && !rd_last_ff) |=> state_ff == S_RD_ISSUE)
      else $error("Receive burst stopped before its last item.");

endmodule

>>> verif/mcfb_result_check.sv
// Result checker for the multi-channel bounded FIFO bus: watches both channels, keeps its own
// copy of the slots and their words, and compares every result with the expected one.
// Depends on mcfb_pkg for the request and status codes and the slot sizes.
module mcfb_result_check
   import mcfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_channel_sel,
   input  logic [31:0] req_send_data,
   input  logic [4:0]  req_limit_words,
   input  logic [4:0]  req_burst_count,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [2:0]  rsp_opened_id,
   input  logic [31:0] rsp_recv_data,
   input  logic        rsp_last,
   output int          results_owed,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OWED_DEPTH = 64;

   typedef struct packed {
      status_type  status;
      logic [2:0]  opened_id;
      logic [31:0] recv_data;
      logic        last;
   } bus_result_type;

   bus_result_type    owed_results [OWED_DEPTH];
   logic              slot_open    [NUM_CHANNELS];
   logic [4:0]        slot_limit   [NUM_CHANNELS];
   logic [PTR_W-1:0]  read_ptr     [NUM_CHANNELS];
   logic [FILL_W-1:0] fill_count   [NUM_CHANNELS];
   logic [31:0]       word_ring    [NUM_CHANNELS][CHANNEL_DEPTH];
   int                owed_rd = 0;
   int                owed_wr = 0;
   int                owed_count = 0;
   int                mismatch_count = 0;

   assign results_owed = owed_count;
   assign fail_count   = mismatch_count;

   function automatic bus_result_type make_result(status_type st, logic [2:0] id,
                                                  logic [31:0] data, logic fin);
      return '{st, id, data, fin};
   endfunction

   task automatic owe_result(input bus_result_type r);
      owed_results[owed_wr % OWED_DEPTH] = r;
      owed_wr++;
   endtask

   task automatic ring_push(input int s, input logic [31:0] word);
      logic [PTR_W-1:0] pos;
      pos = read_ptr[s] + PTR_W'(fill_count[s]);
      word_ring[s][pos] = word;
      fill_count[s] = fill_count[s] + 1'b1;
   endtask

   task automatic apply_request(input logic [2:0] kind, input logic [2:0] sel,
                                input logic [31:0] data, input logic [4:0] lim,
                                input logic [4:0] burst);
      int  s;
      int  n;
      bit  found;
      bit  any_open;
      bit  any_full;
      logic [31:0] word;
      case (kind)
         REQ_OPEN: begin
            found = 1'b0;
            for (s = 0; s < NUM_CHANNELS && !found; s++) begin
               if (!slot_open[s]) begin
                  found         = 1'b1;
                  slot_open[s]  = 1'b1;
                  slot_limit[s] = (lim > CHANNEL_DEPTH) ? 5'(CHANNEL_DEPTH) : lim;
                  read_ptr[s]   = '0;
                  fill_count[s] = '0;
                  owe_result(make_result(ST_OK, 3'(s), '0, 1'b1));
               end
            end
            if (!found) begin
               owe_result(make_result(ST_NO_FREE_SLOT, '0, '0, 1'b1));
            end
         end
         REQ_CLOSE: begin
            if (slot_open[sel]) begin
               slot_open[sel]  = 1'b0;
               slot_limit[sel] = '0;
               read_ptr[sel]   = '0;
               fill_count[sel] = '0;
            end
            owe_result(make_result(ST_OK, '0, '0, 1'b1));
         end
         REQ_SEND: begin
            if (!slot_open[sel]) begin
               owe_result(make_result(ST_NO_CHANNEL, '0, '0, 1'b1));
            end else if (fill_count[sel] >= slot_limit[sel]) begin
               owe_result(make_result(ST_WOULD_BLOCK, '0, '0, 1'b1));
            end else begin
               ring_push(sel, data);
               owe_result(make_result(ST_OK, '0, '0, 1'b1));
            end
         end
         REQ_RECV: begin
            if (!slot_open[sel]) begin
               owe_result(make_result(ST_NO_CHANNEL, '0, '0, 1'b1));
            end else if (fill_count[sel] == 0) begin
               owe_result(make_result(ST_WOULD_BLOCK, '0, '0, 1'b1));
            end else begin
               n = (burst == 0) ? 1 : int'(burst);
               if (n > BURST_CAP) begin
                  n = BURST_CAP;
               end
               while (n > 0 && fill_count[sel] != 0) begin
                  word            = word_ring[sel][read_ptr[sel]];
                  read_ptr[sel]   = read_ptr[sel] + 1'b1;
                  fill_count[sel] = fill_count[sel] - 1'b1;
                  n--;
                  owe_result(make_result(ST_OK, '0, word,
                                         (n == 0) || (fill_count[sel] == 0)));
               end
            end
         end
         REQ_BCAST: begin
            any_open = 1'b0;
            any_full = 1'b0;
            for (s = 0; s < NUM_CHANNELS; s++) begin
               if (slot_open[s]) begin
                  any_open = 1'b1;
                  if (fill_count[s] >= slot_limit[s]) begin
                     any_full = 1'b1;
                  end
               end
            end
            if (any_full) begin
               owe_result(make_result(ST_WOULD_BLOCK, '0, '0, 1'b1));
            end else if (!any_open) begin
               owe_result(make_result(ST_NO_CHANNEL, '0, '0, 1'b1));
            end else begin
               for (s = 0; s < NUM_CHANNELS; s++) begin
                  if (slot_open[s]) begin
                     ring_push(s, data);
                  end
               end
               owe_result(make_result(ST_OK, '0, '0, 1'b1));
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      bus_result_type want;
      int             s;
      if (reset) begin
         owed_rd = owed_wr;
         for (s = 0; s < NUM_CHANNELS; s++) begin
            slot_open[s]  = 1'b0;
            slot_limit[s] = '0;
            read_ptr[s]   = '0;
            fill_count[s] = '0;
         end
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_wr == owed_rd) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected item status=%0d id=%0d data=%h last=%b", $realtime,
                           rsp_status, rsp_opened_id, rsp_recv_data, rsp_last);
               end
            end else begin
               want = owed_results[owed_rd % OWED_DEPTH];
               owed_rd++;
               if (rsp_status !== want.status || rsp_opened_id !== want.opened_id ||
                   rsp_recv_data !== want.recv_data || rsp_last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: expected status=%0d id=%0d data=%h last=%b", $realtime,
                              want.status, want.opened_id, want.recv_data, want.last);
                     $display("%0t:   actual status=%0d id=%0d data=%h last=%b", $realtime,
                              rsp_status, rsp_opened_id, rsp_recv_data, rsp_last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_request(req_type, req_channel_sel, req_send_data, req_limit_words,
                          req_burst_count);
         end
      end
      owed_count <= owed_wr - owed_rd;
   end

endmodule

>>> verif/tb_multi_channel_bounded_fifo_bus.sv
// Top of the testbench for the multi-channel bounded FIFO bus: clock, reset, request stimulus
// and receiver stalls, with the verdict taken from mcfb_result_check.
// Depends on mcfb_pkg, multi_channel_bounded_fifo_bus and mcfb_result_check.
module tb_multi_channel_bounded_fifo_bus;
   timeunit 1ns;
   timeprecision 1ps;
   import mcfb_pkg::*;

   localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] REQ_LAST_CODE    = 3'd7;
   localparam int         HOLD_CYCLES      = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_type;
   logic [2:0]  req_channel_sel;
   logic [31:0] req_send_data;
   logic [4:0]  req_limit_words;
   logic [4:0]  req_burst_count;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_opened_id;
   logic [31:0] rsp_recv_data;
   logic        rsp_last;

   logic hold_go = 1'b0;
   int   hold_left = 0;
   int   send_idle_pct = 25;
   int   recv_idle_pct = 52;
   int   issued = 0;
   int   results_owed;
   int   fail_count;

   multi_channel_bounded_fifo_bus uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_channel_sel (req_channel_sel),
      .req_send_data   (req_send_data),
      .req_limit_words (req_limit_words),
      .req_burst_count (req_burst_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_opened_id   (rsp_opened_id),
      .rsp_recv_data   (rsp_recv_data),
      .rsp_last        (rsp_last)
   );

   mcfb_result_check result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_channel_sel (req_channel_sel),
      .req_send_data   (req_send_data),
      .req_limit_words (req_limit_words),
      .req_burst_count (req_burst_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_opened_id   (rsp_opened_id),
      .rsp_recv_data   (rsp_recv_data),
      .rsp_last        (rsp_last),
      .results_owed    (results_owed),
      .fail_count      (fail_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_go) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic offer(input logic [2:0] kind, input logic [2:0] sel, input logic [31:0] data,
                        input logic [4:0] lim, input logic [4:0] burst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_channel_sel <= sel;
      req_send_data   <= data;
      req_limit_words <= lim;
      req_burst_count <= burst;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      if (kind <= REQ_BCAST) begin
         issued++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_request();
      int          pick;
      logic [4:0]  lim;
      logic [2:0]  kind;
      pick = $urandom_range(99);
      lim  = ($urandom_range(9) == 0) ? 5'($urandom_range(31, CHANNEL_DEPTH + 1))
                                      : 5'($urandom_range(CHANNEL_DEPTH));
      if (pick < 12) begin
         kind = REQ_OPEN;
      end else if (pick < 22) begin
         kind = REQ_CLOSE;
      end else if (pick < 52) begin
         kind = REQ_SEND;
      end else if (pick < 77) begin
         kind = REQ_RECV;
      end else if (pick < 92) begin
         kind = REQ_BCAST;
      end else begin
         kind = 3'($urandom_range(REQ_LAST_CODE, REQ_FIRST_UNUSED));
      end
      offer(kind, 3'($urandom_range(NUM_CHANNELS - 1)), pick_word(), lim,
            5'($urandom_range(31)));
   endtask

   task automatic fill_and_drain();
      logic [2:0] sel;
      int         words;
      int         k;
      sel   = 3'($urandom_range(NUM_CHANNELS - 1));
      words = $urandom_range(1, CHANNEL_DEPTH);
      for (k = 0; k < words; k++) begin
         offer(REQ_SEND, sel, pick_word(), 5'($urandom), 5'($urandom));
      end
      offer(REQ_RECV, sel, pick_word(), 5'($urandom), 5'($urandom_range(31)));
   endtask

   task automatic random_phase(input int items);
      int target;
      target = issued + items;
      while (issued < target) begin
         if ($urandom_range(99) < 15) begin
            fill_and_drain();
         end else begin
            random_request();
         end
      end
   endtask

   initial begin
      logic [4:0] open_limits [7];
      int         k;
      open_limits = '{5'd31, 5'd16, 5'd1, 5'd3, 5'd5, 5'd2, 5'd17};
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_type        <= REQ_OPEN;
      req_channel_sel <= '0;
      req_send_data   <= '0;
      req_limit_words <= '0;
      req_burst_count <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      offer(REQ_RECV, 3'd0, 32'h0, 5'd0, 5'd1);
      offer(REQ_SEND, 3'd7, 32'hFFFF_FFFF, 5'd0, 5'd0);
      offer(REQ_BCAST, 3'd0, 32'h1234_5678, 5'd0, 5'd0);
      offer(REQ_CLOSE, 3'd5, 32'h0, 5'd0, 5'd0);
      offer(REQ_OPEN, 3'd0, 32'h0, 5'd0, 5'd0);
      offer(REQ_SEND, 3'd0, 32'h5A5A_5A5A, 5'd0, 5'd0);
      offer(REQ_BCAST, 3'd0, 32'h0F0F_0F0F, 5'd0, 5'd0);
      for (k = 0; k < 7; k++) begin
         offer(REQ_OPEN, 3'd0, 32'h0, open_limits[k], 5'd0);
      end
      offer(REQ_OPEN, 3'd0, 32'h0, 5'd4, 5'd0);
      offer(REQ_CLOSE, 3'd0, 32'h0, 5'd0, 5'd0);
      offer(REQ_BCAST, 3'd7, 32'hFFFF_FFFF, 5'd31, 5'd31);
      offer(REQ_BCAST, 3'd0, 32'h0, 5'd0, 5'd0);
      offer(REQ_SEND, 3'd1, 32'hA5A5_A5A5, 5'd0, 5'd0);
      offer(REQ_SEND, 3'd3, 32'h3C3C_3C3C, 5'd0, 5'd0);
      offer(REQ_RECV, 3'd1, 32'h0, 5'd0, 5'd0);
      offer(REQ_RECV, 3'd1, 32'h0, 5'd0, 5'd31);
      offer(REQ_RECV, 3'd1, 32'h0, 5'd0, 5'd5);
      for (k = REQ_FIRST_UNUSED; k <= REQ_LAST_CODE; k++) begin
         offer(3'(k), 3'($urandom), $urandom, 5'($urandom), 5'($urandom));
      end
      drain();

      // The receiver holds off while the requests keep coming, so the block backs up.
      send_idle_pct = 0;
      hold_go <= 1'b1;
      offer(REQ_SEND, 3'd2, pick_word(), 5'd0, 5'd0);
      hold_go <= 1'b0;
      for (k = 0; k < 30; k++) begin
         offer(($urandom_range(3) == 0) ? REQ_BCAST : REQ_SEND,
               3'($urandom_range(NUM_CHANNELS - 1)), pick_word(), 5'd0, 5'd0);
      end
      drain();

      send_idle_pct = 25;
      recv_idle_pct = 52;
      random_phase(30);
      drain();
      send_idle_pct = 52;
      recv_idle_pct = 25;
      random_phase(30);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(30);

      req_valid <= 1'b0;
      for (k = 0; k < 50000 && results_owed != 0; k++) begin
         @(posedge clock);
      end
      repeat (4 * NUM_CHANNELS + 8) @(posedge clock);
      if (fail_count == 0 && results_owed == 0) begin
         $display("multi_channel_bounded_fifo_bus verification clean");
      end else begin
         $display("multi_channel_bounded_fifo_bus verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("multi_channel_bounded_fifo_bus verification failed");
      $finish;
   end

endmodule
